// ----- rtl/llbs_pkg.sv -----
// Shared constants, field widths and the sequencer state type of the largest-layer scheduler.
package llbs_pkg;

  // Default sizing of the block.
  localparam int unsigned MAX_LAYERS_DEF = 64;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed field widths of the request and result items.
  localparam int unsigned LAYER_W    = 6;
  localparam int unsigned TOKEN_W    = 12;
  localparam int unsigned OUT_TOK_W  = 16;
  localparam int unsigned ACTIVE_W   = 7;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 2;

  // Reset value of the active layer count.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 7'd64;

  // Request kinds carried on the input tuser.
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_RESP
  } llbs_state_e;

endpackage

// ----- rtl/largest_layer_batch_scheduler_top.sv -----
// Largest-layer batch scheduler: per-layer pending token counts with a tracked leader.
//
// Each request produces exactly one result. An add request to an active layer reads the
// layer's count from the count memory, does one saturating add and compare, then loads
// the result; an add to a layer at or above the active count goes straight to the
// result load. A fetch that finds a leader clears the granted layer's count, then reads
// all n active counts, where n is min(active_layers, MAX_LAYERS), one per cycle from the
// single read port of the count memory and compares them against the running best with
// the one shared comparator, lowest index winning ties. A fetch with no leader goes
// straight to the result load. The result is loaded once the output register is free.
// The input is ready only while the sequencer is idle; a finished result sits in the
// output register while the next request is taken. The count memory needs no clearing
// pass after reset, so the input is ready straight out of reset.
module largest_layer_batch_scheduler_top #(
  parameter int unsigned MAX_LAYERS = llbs_pkg::MAX_LAYERS_DEF,
  parameter int unsigned COUNT_BITS = llbs_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: active_layers.
  input  logic                            cfg_we_i,
  input  logic [llbs_pkg::ACTIVE_W-1:0]   cfg_wdata_i,
  // Request stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: layer [5:0], token_count [17:6], zero [23:18].
  input  logic [llbs_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: action [0].
  input  logic                            s_axis_tuser_i,
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: chosen_layer [5:0], chosen_tokens [21:6], zero [23:22].
  output logic [llbs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: granted [0], empty_res [1].
  output logic [llbs_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);
  import llbs_pkg::*;

  localparam int unsigned IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LAYERS + 1);
  localparam int unsigned NW    = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
  localparam int unsigned LW    = (CNT_W > LAYER_W) ? CNT_W : LAYER_W;

  // Request fields.
  logic               in_action;
  logic [LAYER_W-1:0] in_layer;
  logic [TOKEN_W-1:0] in_tokens;
  logic               in_acc;

  // Sequencer and leader state.
  llbs_state_e           state_q, state_d;
  logic [ACTIVE_W-1:0]   active_q;
  logic                  leader_valid_q, leader_valid_d;
  logic [COUNT_BITS-1:0] leader_size_q, leader_size_d;
  logic [IDX_W-1:0]      leader_layer_q, leader_layer_d;
  logic [IDX_W-1:0]      layer_idx_q, layer_idx_d;
  logic [TOKEN_W-1:0]    tokens_q, tokens_d;
  logic                  grant_q, grant_d;
  logic [IDX_W-1:0]      got_layer_q, got_layer_d;
  logic [COUNT_BITS-1:0] got_size_q, got_size_d;
  logic [CNT_W-1:0]      scan_idx_q, scan_idx_d;
  logic                  pipe_vld_q, pipe_vld_d;
  logic [IDX_W-1:0]      pipe_idx_q, pipe_idx_d;

  // Result register.
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [OUT_USER_W-1:0] m_user_q, m_user_d;

  // Memory and shared unit connections.
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;
  logic                  alu_use_sum, alu_gt;
  logic [COUNT_BITS-1:0] alu_result;

  // Effective number of active layers.
  logic [NW-1:0]    act_ext;
  logic [CNT_W-1:0] n_act;
  logic             layer_active;

  assign in_action = s_axis_tuser_i;
  assign in_layer  = s_axis_tdata_i[LAYER_W-1:0];
  assign in_tokens = s_axis_tdata_i[LAYER_W +: TOKEN_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign act_ext      = NW'(active_q);
  assign n_act        = (act_ext > NW'(MAX_LAYERS)) ? CNT_W'(MAX_LAYERS) : CNT_W'(act_ext);
  assign layer_active = LW'(in_layer) < LW'(n_act);

  llbs_count_mem #(
    .DEPTH  (MAX_LAYERS),
    .WIDTH  (COUNT_BITS),
    .ADDR_W (IDX_W)
  ) u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  llbs_alu #(
    .COUNT_BITS (COUNT_BITS)
  ) u_alu (
    .count_i   (mem_rdata),
    .tokens_i  (tokens_q),
    .use_sum_i (alu_use_sum),
    .ref_i     (leader_size_q),
    .result_o  (alu_result),
    .gt_o      (alu_gt)
  );

  // Sequencer: next state, memory requests, leader updates and result load.
  always_comb begin
    state_d        = state_q;
    leader_valid_d = leader_valid_q;
    leader_size_d  = leader_size_q;
    leader_layer_d = leader_layer_q;
    layer_idx_d    = layer_idx_q;
    tokens_d       = tokens_q;
    grant_d        = grant_q;
    got_layer_d    = got_layer_q;
    got_size_d     = got_size_q;
    scan_idx_d     = scan_idx_q;
    pipe_vld_d     = 1'b0;
    pipe_idx_d     = pipe_idx_q;
    m_valid_d      = m_valid_q && !m_axis_tready_i;
    m_data_d       = m_data_q;
    m_user_d       = m_user_q;
    mem_we         = 1'b0;
    mem_waddr      = leader_layer_q;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = IDX_W'(in_layer);
    alu_use_sum    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          layer_idx_d = IDX_W'(in_layer);
          tokens_d    = in_tokens;
          grant_d     = 1'b0;
          if (in_action == ACT_ADD) begin
            // Fetch the layer's count; inactive layers are left alone.
            if (layer_active) begin
              mem_re  = 1'b1;
              state_d = ST_ADD;
            end else begin
              state_d = ST_RESP;
            end
          end else if (leader_valid_q) begin
            // Grant the leader, clear its count and start a fresh rescan.
            grant_d        = 1'b1;
            got_layer_d    = leader_layer_q;
            got_size_d     = leader_size_q;
            mem_we         = 1'b1;
            leader_valid_d = 1'b0;
            leader_size_d  = '0;
            leader_layer_d = '0;
            scan_idx_d     = '0;
            state_d        = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_ADD: begin
        // Saturating credit, written back; a strictly larger total takes the lead.
        alu_use_sum = 1'b1;
        mem_we      = 1'b1;
        mem_waddr   = layer_idx_q;
        mem_wdata   = alu_result;
        if (alu_gt) begin
          leader_valid_d = 1'b1;
          leader_size_d  = alu_result;
          leader_layer_d = layer_idx_q;
        end
        state_d = ST_RESP;
      end

      ST_SCAN: begin
        // Issue one read per cycle while each compare follows in the cycle after its read.
        if (scan_idx_q < n_act) begin
          mem_re     = 1'b1;
          mem_raddr  = scan_idx_q[IDX_W-1:0];
          pipe_vld_d = 1'b1;
          pipe_idx_d = scan_idx_q[IDX_W-1:0];
          scan_idx_d = scan_idx_q + CNT_W'(1);
        end else if (!pipe_vld_q) begin
          state_d = ST_RESP;
        end
        if (pipe_vld_q && alu_gt) begin
          leader_valid_d = 1'b1;
          leader_size_d  = mem_rdata;
          leader_layer_d = pipe_idx_q;
        end
      end

      ST_RESP: begin
        // Load the result once the output register is free.
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_user_d  = {!leader_valid_q, grant_q};
          if (grant_q) begin
            m_data_d = {2'b00, OUT_TOK_W'(got_size_q), LAYER_W'(got_layer_q)};
          end else begin
            m_data_d = {2'b00, OUT_TOK_W'(leader_size_q), LAYER_W'(leader_layer_q)};
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and leader registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      active_q       <= ACTIVE_RST;
      leader_valid_q <= 1'b0;
      leader_size_q  <= '0;
      leader_layer_q <= '0;
      scan_idx_q     <= '0;
      pipe_vld_q     <= 1'b0;
      grant_q        <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      leader_valid_q <= leader_valid_d;
      leader_size_q  <= leader_size_d;
      leader_layer_q <= leader_layer_d;
      scan_idx_q     <= scan_idx_d;
      pipe_vld_q     <= pipe_vld_d;
      grant_q        <= grant_d;
      m_valid_q      <= m_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    layer_idx_q <= layer_idx_d;
    tokens_q    <= tokens_d;
    got_layer_q <= got_layer_d;
    got_size_q  <= got_size_d;
    pipe_idx_q  <= pipe_idx_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // Without a leader the tracked size and layer sit at zero.
  a_no_leader_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !leader_valid_q |-> (leader_size_q == '0) && (leader_layer_q == '0))
    else $error("leader size or layer nonzero without a leader");

  // A leader always holds pending tokens.
  a_leader_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    leader_valid_q |-> (leader_size_q != '0))
    else $error("leader with zero tokens");

  // A granting fetch drops the leader before the rescan begins.
  a_fetch_drops_leader : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_action == ACT_FETCH) && leader_valid_q) |=>
      (!leader_valid_q && (state_q == ST_SCAN)))
    else $error("fetch did not clear the leader");

  // A new result only appears after the result step of the sequencer.
  a_result_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !$past(m_axis_tvalid_o)) |-> ($past(state_q) == ST_RESP))
    else $error("result loaded outside the result step");

  // The scan never reads past the active layer count.
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_idx_q <= n_act))
    else $error("scan index beyond active layers");

endmodule

// ----- rtl/llbs_count_mem.sv -----
// Pending token count memory with one write and one registered read port and per-entry valid bits.
module llbs_count_mem #(
  parameter int unsigned DEPTH  = llbs_pkg::MAX_LAYERS_DEF,
  parameter int unsigned WIDTH  = llbs_pkg::COUNT_BITS_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  import llbs_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;

  // Storage array; entries are only meaningful once their valid bit is set.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Valid bits stand in for clearing the array after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // Registered read; an entry never written reads as zero.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/llbs_alu.sv -----
// Shared saturating adder and greater-than comparator used by both add and rescan steps.
module llbs_alu #(
  parameter int unsigned COUNT_BITS = llbs_pkg::COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0]        count_i,
  input  logic [llbs_pkg::TOKEN_W-1:0] tokens_i,
  input  logic                         use_sum_i,
  input  logic [COUNT_BITS-1:0]        ref_i,
  output logic [COUNT_BITS-1:0]        result_o,
  output logic                         gt_o
);
  import llbs_pkg::*;

  localparam int unsigned SUM_W =
    ((COUNT_BITS > TOKEN_W) ? COUNT_BITS : TOKEN_W) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] sat;

  // Saturating add of the arriving tokens when use_sum_i is set, then one compare against the leader.
  always_comb begin
    sum      = SUM_W'(count_i) + SUM_W'(tokens_i);
    sat      = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(sum);
    result_o = use_sum_i ? sat : count_i;
    gt_o     = result_o > ref_i;
  end

endmodule
